// File: rtl/core/websocket_frame_deframer_assert.svh
// Assertion macros for the deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication.
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// File: rtl/core/wsd_pkg.sv
`default_nettype none

package wsd_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic       KIND_HEADER  = 1'b0;
    localparam logic       KIND_PAYLOAD = 1'b1;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        logic        kind;
        logic        fin;
        logic [2:0]  reserved_bits;
        logic [3:0]  frame_opcode;
        logic        is_masked;
        logic [63:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/wsd_if.sv
`default_nettype none

interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsd_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        fin;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic        is_masked;
    logic [63:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;

    modport source (output valid, output kind, output fin, output reserved_bits,
                    output frame_opcode, output is_masked, output payload_length,
                    output payload_byte, output last, input ready);
    modport sink   (input valid, input kind, input fin, input reserved_bits,
                    input frame_opcode, input is_masked, input payload_length,
                    input payload_byte, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/wsd_parser.sv
`default_nettype none

module wsd_parser (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    wsd_byte_if.sink      i_in,
    input  wire logic     i_queue_full,
    output logic          o_push,
    output wsd_pkg::t_result o_entry
);
    import wsd_pkg::*;

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_PAY  = 3'd4;

    logic [2:0]       r_phase, n_phase;
    logic [2:0]       r_count, n_count;
    logic             r_fin, n_fin;
    logic [2:0]       r_rsv, n_rsv;
    logic [3:0]       r_opc, n_opc;
    logic             r_mask, n_mask;
    logic [63:0]      r_len, n_len;
    logic [3:0][7:0]  r_key, n_key;
    logic [63:0]      r_rem, n_rem;
    logic [1:0]       r_kpos, n_kpos;

    logic             accept;
    logic [7:0]       b;
    logic             len_done;
    logic             hdr_done;
    logic             e_kind;
    logic [7:0]       e_byte;
    logic             e_last;

    assign i_in.ready = !i_queue_full;
    assign accept     = i_in.valid && !i_queue_full;
    assign b          = i_in.stream_byte;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_fin    = r_fin;
        n_rsv    = r_rsv;
        n_opc    = r_opc;
        n_mask   = r_mask;
        n_len    = r_len;
        n_key    = r_key;
        n_rem    = r_rem;
        n_kpos   = r_kpos;
        len_done = 1'b0;
        hdr_done = 1'b0;
        o_push   = 1'b0;
        e_kind   = KIND_HEADER;
        e_byte   = 8'd0;
        e_last   = 1'b0;
        if (accept) begin
            unique case (r_phase)
                PH_HDR1: begin
                    n_mask = b[7];
                    n_len  = 64'd0;
                    if (b[6:0] == LEN_EXT16) begin
                        n_phase = PH_EXT;
                        n_count = 3'd2;
                    end else if (b[6:0] == LEN_EXT64) begin
                        n_phase = PH_EXT;
                        n_count = 3'd0; // eight bytes, wraps through zero
                    end else begin
                        n_len    = {57'd0, b[6:0]};
                        len_done = 1'b1;
                    end
                end
                PH_EXT: begin
                    n_len   = {r_len[55:0], b};
                    n_count = r_count - 3'd1;
                    len_done = (n_count == 3'd0);
                end
                PH_KEY: begin
                    n_key   = {r_key[2:0], b};
                    n_count = r_count - 3'd1;
                    hdr_done = (n_count == 3'd0);
                end
                PH_PAY: begin
                    o_push = 1'b1;
                    e_kind = KIND_PAYLOAD;
                    e_byte = r_mask ? (b ^ r_key[2'd3 - r_kpos]) : b;
                    e_last = (r_rem[63:1] == 63'd0);
                    n_kpos = r_kpos + 2'd1;
                    if (r_rem != 64'd0) begin
                        n_rem = r_rem - 64'd1;
                    end
                    if (e_last) begin
                        n_phase = PH_HDR0;
                    end
                end
                default: begin
                    n_fin   = b[7];
                    n_rsv   = b[6:4];
                    n_opc   = b[3:0];
                    n_phase = PH_HDR1;
                end
            endcase
            if (len_done) begin
                n_key = '0;
                if (n_mask) begin
                    n_phase = PH_KEY;
                    n_count = 3'd4;
                end else begin
                    hdr_done = 1'b1;
                end
            end
            if (hdr_done) begin
                n_rem   = n_len;
                n_kpos  = 2'd0;
                o_push  = 1'b1;
                e_last  = (n_len == 64'd0);
                n_phase = e_last ? PH_HDR0 : PH_PAY;
            end
        end
    end

    always_comb begin
        o_entry.kind           = e_kind;
        o_entry.fin            = n_fin;
        o_entry.reserved_bits  = n_rsv;
        o_entry.frame_opcode   = n_opc;
        o_entry.is_masked      = n_mask;
        o_entry.payload_length = n_len;
        o_entry.payload_byte   = e_byte;
        o_entry.last           = e_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_count <= 3'd0;
            r_fin   <= 1'b0;
            r_rsv   <= 3'd0;
            r_opc   <= 4'd0;
            r_mask  <= 1'b0;
            r_len   <= 64'd0;
            r_key   <= '0;
            r_rem   <= 64'd0;
            r_kpos  <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_fin   <= n_fin;
            r_rsv   <= n_rsv;
            r_opc   <= n_opc;
            r_mask  <= n_mask;
            r_len   <= n_len;
            r_key   <= n_key;
            r_rem   <= n_rem;
            r_kpos  <= n_kpos;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wsd_fifo.sv
`default_nettype none

module wsd_fifo #(
    parameter int P_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire wsd_pkg::t_result i_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_nonempty,
    output wsd_pkg::t_result      o_head
);
    import wsd_pkg::*;

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(P_DEPTH);

    t_result       r_mem [P_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full     = (r_count == FULL_CNT);
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wsd_emit.sv
`default_nettype none

module wsd_emit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_nonempty,
    input  wire wsd_pkg::t_result i_head,
    output logic             o_pop,
    wsd_result_if.source     o_out
);
    import wsd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_data;

    assign o_pop   = i_nonempty && (!r_valid || o_out.ready);
    assign n_valid = o_pop || (r_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.kind           = r_data.kind;
    assign o_out.fin            = r_data.fin;
    assign o_out.reserved_bits  = r_data.reserved_bits;
    assign o_out.frame_opcode   = r_data.frame_opcode;
    assign o_out.is_masked      = r_data.is_masked;
    assign o_out.payload_length = r_data.payload_length;
    assign o_out.payload_byte   = r_data.payload_byte;
    assign o_out.last           = r_data.last;

endmodule

`default_nettype wire

// File: rtl/core/websocket_frame_deframer.sv
// Channel   Dir  Beat
// i_in      in   one raw stream byte (stream_byte)
// o_out     out  header result or one unmasked payload byte, last on frame end
//
// One stream byte is taken per cycle unless the result queue is full; parser state is registered.
// Each result is queued when its byte is accepted and then moves into the output register.
// i_rst_n is synchronous and active low; after reset the parser expects header byte zero.
// A two-entry result queue sits between parser and output register; i_in.ready
// drops only when that queue is full, so o_out stalls reach the input only once it has filled.
`default_nettype none

module websocket_frame_deframer #(
    parameter int P_QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    wsd_byte_if.sink     i_in,
    wsd_result_if.source o_out
);
    import wsd_pkg::*;

    logic    queue_full;
    logic    queue_nonempty;
    logic    push;
    logic    pop;
    t_result entry;
    t_result head;

    wsd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_entry      (entry)
    );

    wsd_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (entry),
        .i_pop      (pop),
        .o_full     (queue_full),
        .o_nonempty (queue_nonempty),
        .o_head     (head)
    );

    wsd_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (queue_nonempty),
        .i_head     (head),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

// File: rtl/core/wsd_checker.sv
`default_nettype none

`include "websocket_frame_deframer_assert.svh"

module wsd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_kind,
    input wire logic [63:0] i_payload_length,
    input wire logic [7:0]  i_payload_byte,
    input wire logic        i_last
);
    import wsd_pkg::*;

    logic stalled;
    logic hdr_beat;
    logic pay_beat;

    assign stalled  = i_out_valid && !i_out_ready;
    assign hdr_beat = i_out_valid && (i_kind == KIND_HEADER);
    assign pay_beat = i_out_valid && (i_kind == KIND_PAYLOAD);

    `WSD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, stalled,
        i_out_valid && $stable(i_payload_byte) && $stable(i_last) && $stable(i_kind))

    `WSD_ASSERT_NOW(a_hdr_byte_zero, i_clk, i_rst_n, hdr_beat, i_payload_byte == 8'd0)

    `WSD_ASSERT_NOW(a_hdr_last_empty, i_clk, i_rst_n, hdr_beat,
        i_last == (i_payload_length == 64'd0))

    `WSD_ASSERT_NOW(a_single_byte_last, i_clk, i_rst_n,
        pay_beat && (i_payload_length == 64'd1), i_last)

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_kind           (o_out.kind),
    .i_payload_length (o_out.payload_length),
    .i_payload_byte   (o_out.payload_byte),
    .i_last           (o_out.last)
);

`default_nettype wire
